// File: rtl/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

    localparam int MAX_FRAMES  = 64;
    localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
    localparam int COUNT_W     = 7;
    localparam int TIMER_W     = 27;
    localparam int TIMER_OUT_W = 26;
    localparam int DUR_MS_W    = 16;
    localparam int DUR_US_W    = 26;
    localparam int ELAPSED_W   = 20;

    localparam logic [ELAPSED_W-1:0] TICK_LIMIT_US = ELAPSED_W'(100000);
    localparam logic [DUR_US_W-1:0]  US_PER_MS     = DUR_US_W'(1000);
    localparam logic [COUNT_W-1:0]   FRAME_LIMIT   = COUNT_W'(MAX_FRAMES);

    typedef enum logic [2:0] {
        FUNC_TICK     = 3'd0,
        FUNC_PLAY     = 3'd1,
        FUNC_PAUSE    = 3'd2,
        FUNC_STOP     = 3'd3,
        FUNC_SEEK     = 3'd4,
        FUNC_SET_LOOP = 3'd5,
        FUNC_LOAD     = 3'd6,
        FUNC_NOP      = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WAIT,
        ST_STEP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                   en;
        logic [FRAME_IDX_W-1:0] addr;
    } table_rd_t;

    typedef struct packed {
        logic                   en;
        logic [FRAME_IDX_W-1:0] addr;
        logic [DUR_MS_W-1:0]    data;
    } table_wr_t;

endpackage

`default_nettype wire

// File: rtl/sfs_dur_table.sv
`default_nettype none

module sfs_dur_table (
    input  wire logic                               aclk,
    input  wire sfs_pkg::table_wr_t                 wr,
    input  wire sfs_pkg::table_rd_t                 rd,
    output logic [sfs_pkg::DUR_US_W-1:0]            dur_us
);

    logic [sfs_pkg::DUR_MS_W-1:0] durations_reg [sfs_pkg::MAX_FRAMES];
    logic [sfs_pkg::DUR_MS_W-1:0] ms_reg;
    logic [sfs_pkg::DUR_US_W-1:0] dur_reg;
    logic [sfs_pkg::DUR_US_W-1:0] ms_eff;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            durations_reg[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            ms_reg <= durations_reg[rd.addr];
        end
    end

    // zero duration counts as 1 ms
    assign ms_eff = (ms_reg == '0) ? sfs_pkg::DUR_US_W'(1)
                                   : sfs_pkg::DUR_US_W'(ms_reg);

    always_ff @(posedge aclk) begin
        dur_reg <= ms_eff * sfs_pkg::US_PER_MS;
    end

    assign dur_us = dur_reg;

endmodule

`default_nettype wire

// File: rtl/sprite_frame_sequencer.sv
`default_nettype none

// One sprite animation channel. Each input beat carries a command (tick, play, pause,
// stop, seek, set loop, load frame duration) and yields exactly one result beat with
// the frame shown, the run state, a seek error flag and the time spent in the frame.
// A tick on a running channel with frames walks the fetch, wait and step states once
// per frame it tries: each step reads the duration table (one registered read port),
// scales the duration to microseconds in a registered multiplier and runs one shared
// subtract-and-compare against the frame timer. Any other beat goes straight to the
// emit state, which fills the output register once it is free. A stalled result beat
// holds the block until the output register frees. A new beat is taken only when the
// previous one has finished; its result may still be waiting in the output register.
// frames_in_use is written through cfg_wr_en/cfg_wr_data; the user must do so only
// while the channel is idle, as the block itself does not enforce it.
module sprite_frame_sequencer (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [sfs_pkg::COUNT_W-1:0]         cfg_wr_data,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [2:0]                          s_func,
    input  wire logic [sfs_pkg::ELAPSED_W-1:0]       s_elapsed_us,
    input  wire logic [sfs_pkg::FRAME_IDX_W-1:0]     s_frame_index,
    input  wire logic                                s_loop_flag,
    input  wire logic [sfs_pkg::DUR_MS_W-1:0]        s_duration_ms,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [sfs_pkg::FRAME_IDX_W-1:0]          m_current_frame,
    output logic                                     m_playing,
    output logic                                     m_seek_error,
    output logic [sfs_pkg::TIMER_OUT_W-1:0]          m_timer_us
);

    sfs_pkg::state_t state_reg, state_next;

    logic [sfs_pkg::COUNT_W-1:0]     frames_in_use_reg;
    logic [sfs_pkg::FRAME_IDX_W-1:0] frame_reg, frame_next;
    logic                            run_reg, run_next;
    logic                            wrap_reg, wrap_next;
    logic [sfs_pkg::TIMER_W-1:0]     timer_reg, timer_next;
    logic                            err_reg, err_next;

    logic                               m_valid_reg, m_valid_next;
    logic [sfs_pkg::FRAME_IDX_W-1:0]    m_frame_reg, m_frame_next;
    logic                               m_playing_reg, m_playing_next;
    logic                               m_err_reg, m_err_next;
    logic [sfs_pkg::TIMER_OUT_W-1:0]    m_timer_reg, m_timer_next;

    sfs_pkg::table_rd_t            rd;
    sfs_pkg::table_wr_t            wr;
    logic [sfs_pkg::DUR_US_W-1:0]  dur_us;

    sfs_pkg::func_t                func;
    logic                          accept;
    logic                          out_free;
    logic [sfs_pkg::COUNT_W-1:0]   count;
    logic [sfs_pkg::FRAME_IDX_W-1:0] last_frame;
    logic                          tick_runs;
    logic                          frame_past_end;
    logic                          at_last;
    logic [sfs_pkg::ELAPSED_W-1:0] elapsed_clamped;
    logic [sfs_pkg::TIMER_W:0]     sub_full;
    logic                          timer_ge;
    logic [sfs_pkg::COUNT_W-1:0]   frame_plus_one;

    sfs_dur_table u_table (
        .aclk   (aclk),
        .wr     (wr),
        .rd     (rd),
        .dur_us (dur_us)
    );

    assign func     = sfs_pkg::func_t'(s_func);
    assign s_ready  = (state_reg == sfs_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign count = (frames_in_use_reg > sfs_pkg::FRAME_LIMIT) ? sfs_pkg::FRAME_LIMIT
                                                               : frames_in_use_reg;
    assign last_frame     = sfs_pkg::FRAME_IDX_W'(count - sfs_pkg::COUNT_W'(1));
    assign tick_runs      = run_reg && (count != '0);
    assign frame_past_end = sfs_pkg::COUNT_W'(frame_reg) >= count;
    assign frame_plus_one = sfs_pkg::COUNT_W'(frame_reg) + sfs_pkg::COUNT_W'(1);
    assign at_last        = frame_plus_one >= count;

    assign elapsed_clamped = (s_elapsed_us > sfs_pkg::TICK_LIMIT_US) ? sfs_pkg::TICK_LIMIT_US
                                                                      : s_elapsed_us;

    // shared subtract and compare
    assign sub_full = {1'b0, timer_reg} - {1'b0, sfs_pkg::TIMER_W'(dur_us)};
    assign timer_ge = !sub_full[sfs_pkg::TIMER_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= sfs_pkg::ST_IDLE;
            frames_in_use_reg <= '0;
            frame_reg         <= '0;
            run_reg           <= 1'b0;
            wrap_reg          <= 1'b0;
            timer_reg         <= '0;
            err_reg           <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg   <= state_next;
            frame_reg   <= frame_next;
            run_reg     <= run_next;
            wrap_reg    <= wrap_next;
            timer_reg   <= timer_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                frames_in_use_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_frame_reg   <= m_frame_next;
        m_playing_reg <= m_playing_next;
        m_err_reg     <= m_err_next;
        m_timer_reg   <= m_timer_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sfs_pkg::ST_IDLE: begin
                if (accept) begin
                    if (func == sfs_pkg::FUNC_TICK && tick_runs) begin
                        state_next = sfs_pkg::ST_FETCH;
                    end else begin
                        state_next = sfs_pkg::ST_EMIT;
                    end
                end
            end
            sfs_pkg::ST_FETCH: state_next = sfs_pkg::ST_WAIT;
            sfs_pkg::ST_WAIT:  state_next = sfs_pkg::ST_STEP;
            sfs_pkg::ST_STEP: begin
                if (timer_ge && !(at_last && !wrap_reg)) begin
                    state_next = sfs_pkg::ST_FETCH;
                end else begin
                    state_next = sfs_pkg::ST_EMIT;
                end
            end
            sfs_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = sfs_pkg::ST_IDLE;
                end
            end
            default: state_next = sfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        frame_next     = frame_reg;
        run_next       = run_reg;
        wrap_next      = wrap_reg;
        timer_next     = timer_reg;
        err_next       = err_reg;
        rd             = '0;
        wr             = '0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_frame_next   = m_frame_reg;
        m_playing_next = m_playing_reg;
        m_err_next     = m_err_reg;
        m_timer_next   = m_timer_reg;

        case (state_reg)
            sfs_pkg::ST_IDLE: begin
                if (accept) begin
                    err_next = 1'b0;
                    case (func)
                        sfs_pkg::FUNC_TICK: begin
                            if (tick_runs) begin
                                if (frame_past_end) begin
                                    frame_next = wrap_reg ? '0 : last_frame;
                                end
                                timer_next = timer_reg + sfs_pkg::TIMER_W'(elapsed_clamped);
                            end
                        end
                        sfs_pkg::FUNC_PLAY: begin
                            wrap_next  = s_loop_flag;
                            frame_next = '0;
                            run_next   = 1'b1;
                            timer_next = '0;
                        end
                        sfs_pkg::FUNC_PAUSE: run_next = 1'b0;
                        sfs_pkg::FUNC_STOP: begin
                            frame_next = '0;
                            run_next   = 1'b0;
                        end
                        sfs_pkg::FUNC_SEEK: begin
                            if (sfs_pkg::COUNT_W'(s_frame_index) >= count) begin
                                err_next = 1'b1;
                            end else begin
                                frame_next = s_frame_index;
                            end
                        end
                        sfs_pkg::FUNC_SET_LOOP: wrap_next = s_loop_flag;
                        sfs_pkg::FUNC_LOAD: begin
                            wr.en   = 1'b1;
                            wr.addr = s_frame_index;
                            wr.data = s_duration_ms;
                        end
                        default: ;
                    endcase
                end
            end
            sfs_pkg::ST_FETCH: begin
                rd.en   = 1'b1;
                rd.addr = frame_reg;
            end
            sfs_pkg::ST_WAIT: ;
            sfs_pkg::ST_STEP: begin
                if (timer_ge) begin
                    timer_next = sub_full[sfs_pkg::TIMER_W-1:0];
                    if (at_last) begin
                        if (wrap_reg) begin
                            frame_next = '0;
                        end else begin
                            frame_next = last_frame;
                            run_next   = 1'b0;
                            timer_next = '0;
                        end
                    end else begin
                        frame_next = sfs_pkg::FRAME_IDX_W'(frame_plus_one);
                    end
                end
            end
            sfs_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_frame_next   = frame_reg;
                    m_playing_next = run_reg;
                    m_err_next     = err_reg;
                    m_timer_next   = timer_reg[sfs_pkg::TIMER_OUT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_current_frame = m_frame_reg;
    assign m_playing       = m_playing_reg;
    assign m_seek_error    = m_err_reg;
    assign m_timer_us      = m_timer_reg;

    // timer never needs its top bit
    a_timer_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !timer_reg[sfs_pkg::TIMER_W-1])
        else $error("frame timer overflow");

    // stepping only on a running channel with frames
    a_step_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sfs_pkg::ST_STEP) |-> (run_reg && count != '0))
        else $error("step on stopped channel");

    // frame in range while walking the table
    a_frame_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sfs_pkg::ST_FETCH || state_reg == sfs_pkg::ST_WAIT ||
         state_reg == sfs_pkg::ST_STEP) |-> !frame_past_end)
        else $error("frame beyond count during tick");

    // a result beat only comes from the emit state
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == sfs_pkg::ST_EMIT))
        else $error("result without emit");

endmodule

`default_nettype wire
